// ----- hdl/polyline_bresenham_plotter_top_macros.svh -----
// assertion macros shared by the checker
`ifndef POLYLINE_BRESENHAM_PLOTTER_TOP_MACROS_SVH
`define POLYLINE_BRESENHAM_PLOTTER_TOP_MACROS_SVH

// checked on every edge out of reset
`define BPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

  localparam int GRID_MAX_DEF = 64;
  localparam int COORD_W      = 6;
  localparam int VALUE_W      = 64;
  localparam int GRID_W       = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int ERR_W        = 9;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALUE = 2'd2;

  typedef enum logic [1:0] {
    REQ_POINT = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_MARK  = 2'd2,
    REQ_CLOSE = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  // sequencer commands to the step unit
  typedef struct packed {
    logic load;   // capture start and end points
    logic init;   // work out deltas, directions and error term
    logic step;   // advance one pixel
  } walk_ctl_t;

  typedef logic [COORD_W-1:0] coord_t;

endpackage

`default_nettype wire

// ----- hdl/polyline_bresenham_plotter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// the first pixel of a request passes the setup and run states into the output register
// a run of n pixels (n up to 64) holds the input until its last pixel is loaded,
//   one pixel per cycle from the shared step unit while the output is taken
// mark requests and requests before the first point leave the input free and show nothing
// reset (synchronous, rst_n low): grid 64 x 64, plot value 0, no polyline started

module polyline_bresenham_plotter_top #(
  parameter int GRID_MAX = bpp_pkg::GRID_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic [bpp_pkg::COORD_W-1:0]    in_coord_x,
  input  wire logic [bpp_pkg::COORD_W-1:0]    in_coord_y,
  input  wire logic                           in_has_value,
  input  wire logic [bpp_pkg::VALUE_W-1:0]    in_new_value,
  // pixel channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bpp_pkg::COORD_W-1:0]         out_pix_x,
  output logic [bpp_pkg::COORD_W-1:0]         out_pix_y,
  output logic [bpp_pkg::VALUE_W-1:0]         out_pix_value,
  output logic                                out_in_grid,
  output logic                                out_last,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [bpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpp_pkg::VALUE_W-1:0]    cfg_wdata
);
  import bpp_pkg::*;

  // largest coordinate, incoming coordinates saturate here
  localparam coord_t CoordMax = coord_t'(GRID_MAX - 1);
  localparam logic [GRID_W-1:0] GridReset = GRID_W'(GRID_MAX);

  state_t state_r, state_nxt;

  // polyline state
  coord_t cur_x_r, cur_y_r, mark_x_r, mark_y_r;
  coord_t cur_x_nxt, cur_y_nxt, mark_x_nxt, mark_y_nxt;
  logic   started_r, started_nxt;
  logic [VALUE_W-1:0] plot_value_r, plot_value_nxt;
  logic [GRID_W-1:0]  grid_width_r, grid_height_r;

  // output register
  logic   out_valid_r, out_valid_nxt;
  coord_t out_x_r, out_y_r;
  logic   out_in_grid_r, out_last_r;
  logic [VALUE_W-1:0] out_value_r;

  walk_ctl_t walk_ctl;
  coord_t    walk_sx, walk_sy, walk_ex, walk_ey;
  coord_t    walk_x, walk_y;
  logic      walk_done;

  logic      accept;
  logic      out_load;
  coord_t    tgt_x, tgt_y;
  req_type_t req;

  // shared step unit: one bresenham step per cycle while the output slot is free or being emptied
  bpp_walk u_walk (
    .clk     (clk),
    .ctl     (walk_ctl),
    .start_x (walk_sx),
    .start_y (walk_sy),
    .end_x   (walk_ex),
    .end_y   (walk_ey),
    .pix_x   (walk_x),
    .pix_y   (walk_y),
    .done    (walk_done)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign req      = req_type_t'(in_req_type);

  // saturate targets beyond the grid parameter
  assign tgt_x = (in_coord_x > CoordMax) ? CoordMax : in_coord_x;
  assign tgt_y = (in_coord_y > CoordMax) ? CoordMax : in_coord_y;

  // a pixel moves into the output register when the slot is free or being emptied
  assign out_load = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    mark_x_nxt     = mark_x_r;
    mark_y_nxt     = mark_y_r;
    started_nxt    = started_r;
    plot_value_nxt = plot_value_r;
    walk_ctl       = '0;
    walk_sx        = cur_x_r;
    walk_sy        = cur_y_r;
    walk_ex        = tgt_x;
    walk_ey        = tgt_y;

    // a default value write also replaces the value in force
    if (cfg_we && cfg_index == CFG_DEFAULT_VALUE) begin
      plot_value_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_POINT: begin
              // a point is walked as a run onto itself: one pixel
              if (in_has_value) begin
                plot_value_nxt = in_new_value;
              end
              cur_x_nxt     = tgt_x;
              cur_y_nxt     = tgt_y;
              mark_x_nxt    = tgt_x;
              mark_y_nxt    = tgt_y;
              started_nxt   = 1'b1;
              walk_sx       = tgt_x;
              walk_sy       = tgt_y;
              walk_ctl.load = 1'b1;
              state_nxt     = ST_SETUP;
            end
            REQ_LINE: begin
              if (started_r) begin
                cur_x_nxt     = tgt_x;
                cur_y_nxt     = tgt_y;
                walk_ctl.load = 1'b1;
                state_nxt     = ST_SETUP;
              end
            end
            REQ_MARK: begin
              if (started_r) begin
                mark_x_nxt = cur_x_r;
                mark_y_nxt = cur_y_r;
              end
            end
            REQ_CLOSE: begin
              // back to the mark, which then becomes current
              if (started_r) begin
                walk_ex       = mark_x_r;
                walk_ey       = mark_y_r;
                cur_x_nxt     = mark_x_r;
                cur_y_nxt     = mark_y_r;
                walk_ctl.load = 1'b1;
                state_nxt     = ST_SETUP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETUP: begin
        walk_ctl.init = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        if (out_load) begin
          if (walk_done) begin
            state_nxt = ST_IDLE;
          end else begin
            walk_ctl.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      mark_x_r      <= '0;
      mark_y_r      <= '0;
      started_r     <= 1'b0;
      plot_value_r  <= '0;
      grid_width_r  <= GridReset;
      grid_height_r <= GridReset;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      mark_x_r     <= mark_x_nxt;
      mark_y_r     <= mark_y_nxt;
      started_r    <= started_nxt;
      plot_value_r <= plot_value_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_GRID_WIDTH) begin
        grid_width_r <= cfg_wdata[GRID_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_GRID_HEIGHT) begin
        grid_height_r <= cfg_wdata[GRID_W-1:0];
      end
    end
  end

  // pixel payload, flagged against the configured grid
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r       <= walk_x;
      out_y_r       <= walk_y;
      out_value_r   <= plot_value_r;
      out_in_grid_r <= ({1'b0, walk_x} < grid_width_r) && ({1'b0, walk_y} < grid_height_r);
      out_last_r    <= walk_done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pix_x     = out_x_r;
  assign out_pix_y     = out_y_r;
  assign out_pix_value = out_value_r;
  assign out_in_grid   = out_in_grid_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/bpp_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpp_walk (
  input  wire logic              clk,
  input  wire bpp_pkg::walk_ctl_t ctl,
  input  wire bpp_pkg::coord_t   start_x,
  input  wire bpp_pkg::coord_t   start_y,
  input  wire bpp_pkg::coord_t   end_x,
  input  wire bpp_pkg::coord_t   end_y,
  output bpp_pkg::coord_t        pix_x,
  output bpp_pkg::coord_t        pix_y,
  output logic                   done
);
  import bpp_pkg::*;

  coord_t x_r, y_r, tx_r, ty_r, dx_r, ady_r;
  logic   sx_r, sy_r;
  logic signed [ERR_W-1:0] err_r;

  coord_t x_nxt, y_nxt, dx_nxt, ady_nxt;
  logic   sx_nxt, sy_nxt;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W:0]   e2;
  logic signed [ERR_W:0]   dx_s, dy_s;
  logic   step_x, step_y;

  always_comb begin
    dx_nxt  = (tx_r >= x_r) ? coord_t'(tx_r - x_r) : coord_t'(x_r - tx_r);
    ady_nxt = (ty_r >= y_r) ? coord_t'(ty_r - y_r) : coord_t'(y_r - ty_r);
    sx_nxt  = (x_r < tx_r);
    sy_nxt  = (y_r < ty_r);

    dx_s   = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx_r});
    dy_s   = -$signed({{(ERR_W+1-COORD_W){1'b0}}, ady_r});
    e2     = {err_r, 1'b0};
    step_x = (e2 > dy_s);
    step_y = (e2 < dx_s);
    err_nxt = ERR_W'({err_r[ERR_W-1], err_r} + (step_x ? dy_s : '0) + (step_y ? dx_s : '0));
    x_nxt  = step_x ? (sx_r ? coord_t'(x_r + 1'b1) : coord_t'(x_r - 1'b1)) : x_r;
    y_nxt  = step_y ? (sy_r ? coord_t'(y_r + 1'b1) : coord_t'(y_r - 1'b1)) : y_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r  <= start_x;
      y_r  <= start_y;
      tx_r <= end_x;
      ty_r <= end_y;
    end else if (ctl.init) begin
      dx_r  <= dx_nxt;
      ady_r <= ady_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      err_r <= ERR_W'($signed({1'b0, dx_nxt}) - $signed({1'b0, ady_nxt}));
    end else if (ctl.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
  end

  assign pix_x = x_r;
  assign pix_y = y_r;
  assign done  = (x_r == tx_r) && (y_r == ty_r);

endmodule

`default_nettype wire

// ----- hdl/bpp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_bresenham_plotter_top_macros.svh"

module bpp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [1:0]                     in_req_type,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [bpp_pkg::COORD_W-1:0]    out_pix_x,
  input wire logic [bpp_pkg::COORD_W-1:0]    out_pix_y,
  input wire logic [bpp_pkg::VALUE_W-1:0]    out_pix_value,
  input wire logic                           out_in_grid,
  input wire logic                           out_last
);
  import bpp_pkg::*;

  // whole pixel payload
  logic [2*COORD_W+VALUE_W+1:0] out_word;
  assign out_word = {out_pix_x, out_pix_y, out_pix_value, out_in_grid, out_last};

  // a shown pixel holds until taken
  `BPP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "pixel changed while stalled")

  // no new request while a run is still in the middle
  `BPP_ASSERT(a_busy_mid_run, out_valid && !out_last |-> !in_ready, "request taken mid run")

  // a taken pixel that is not the last is followed at once by the next
  `BPP_ASSERT(a_run_gapless, out_valid && out_ready && !out_last |=> out_valid, "gap inside a run")

  // a mark request paints nothing and leaves the block free
  `BPP_ASSERT(a_mark_free, in_valid && in_ready && in_req_type == REQ_MARK |=> in_ready, "mark request held the input")

  // nothing is shown straight out of reset
  `BPP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "pixel shown after reset")

endmodule

bind polyline_bresenham_plotter_top bpp_checker u_bpp_checker (.*);

`default_nettype wire
